FILE: rtl/core/top_k_abs_select_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the top-k selector modules
// ---------------------------------------------------------------------------
`ifndef TOP_K_ABS_SELECT_MACROS_SVH
`define TOP_K_ABS_SELECT_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted
`define TKAS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while reset is asserted
`define TKAS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/tkas_pkg.sv
// ---------------------------------------------------------------------------
// tkas_pkg
// Types and constants shared by the top-k magnitude selector.
// ---------------------------------------------------------------------------
package tkas_pkg;

  // Depth of the sorted slot list
  localparam int MAX_KEEP = 16;

  // Field widths
  localparam int MAG_W   = 31;
  localparam int VAL_W   = 32;
  localparam int CLS_W   = 8;
  localparam int IDX_W   = 32;
  localparam int KEEP_W  = 5;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  // Derived widths
  localparam int RANK_W  = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int CNT_W   = $clog2(MAX_KEEP + 1);
  localparam int CMP_W   = (KEEP_W > CNT_W) ? KEEP_W : CNT_W;

  // Register map: word index taken from paddr[2]
  localparam logic REG_KEEP_COUNT = 1'b0;
  localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(16);

  // One kept element
  typedef struct packed {
    logic        [MAG_W-1:0] mag;
    logic signed [VAL_W-1:0] value;
    logic        [CLS_W-1:0] class_alpha;
    logic        [CLS_W-1:0] class_beta;
    logic        [IDX_W-1:0] index_alpha;
    logic        [IDX_W-1:0] index_beta;
  } slot_t;

  // Controller to datapath
  typedef struct packed {
    logic              emit;   // load rank into the result register
    logic              last;   // this rank ends the report
    logic              clear;  // empty the list after the report
    logic [RANK_W-1:0] rank;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [RANK_W-1:0] last_rank;  // report length minus one, incl. current item
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_REPORT
  } state_e;

  // Saturated absolute value of a Q2.30 coefficient
  function automatic logic [MAG_W-1:0] sat_mag(logic [VAL_W-1:0] v);
    logic [VAL_W-1:0] neg;
    neg = ~v + 1'b1;
    if (!v[VAL_W-1]) begin
      return v[MAG_W-1:0];
    end else if (neg[VAL_W-1]) begin
      return {MAG_W{1'b1}};
    end else begin
      return neg[MAG_W-1:0];
    end
  endfunction

endpackage

FILE: rtl/core/top_k_abs_select.sv
// ---------------------------------------------------------------------------
// top_k_abs_select
// Keeps the largest-magnitude Q2.30 coefficients of a vector and reports them.
// ---------------------------------------------------------------------------
// Usage:
//   Input: drive an item on the payload ports with start high; it is taken at
//   the rising edge where start is high and busy is low. While no report runs
//   one item is taken every cycle: all slots compare in parallel and the
//   list shift-inserts in the same cycle.
//   An item with final_item set starts a report of n beats, n = min(K, items
//   in the vector), K being keep_count clamped to 1..16: busy rises the next
//   cycle and stays high until the last rank is loaded into the result
//   register. The beats leave that register one per cycle in rank order,
//   rank_valid_o high for each, end_of_report_o on the last. Empty ranks come
//   out as all-zero beats; no input is taken while busy is high.
//   The receiver cannot stall; every beat shows for exactly one cycle.
//   After the report the list and the item count are empty again.
//   Config: APB, keep_count at byte address 0, pready always high; write only
//   while idle. Reset empties the list and sets keep_count to 16.
// ---------------------------------------------------------------------------
module top_k_abs_select (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Command channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [tkas_pkg::VAL_W-1:0]    coeff_value_i,
  input  logic        [tkas_pkg::CLS_W-1:0]    class_alpha_i,
  input  logic        [tkas_pkg::CLS_W-1:0]    class_beta_i,
  input  logic        [tkas_pkg::IDX_W-1:0]    index_alpha_i,
  input  logic        [tkas_pkg::IDX_W-1:0]    index_beta_i,
  input  logic                                 final_item_i,
  // Result channel
  output logic                                 rank_valid_o,
  output logic        [tkas_pkg::MAG_W-1:0]    rank_magnitude_o,
  output logic signed [tkas_pkg::VAL_W-1:0]    rank_value_o,
  output logic        [tkas_pkg::CLS_W-1:0]    rank_class_alpha_o,
  output logic        [tkas_pkg::CLS_W-1:0]    rank_class_beta_o,
  output logic        [tkas_pkg::IDX_W-1:0]    rank_index_alpha_o,
  output logic        [tkas_pkg::IDX_W-1:0]    rank_index_beta_o,
  output logic                                 end_of_report_o,
  // APB configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic        [tkas_pkg::ADDR_W-1:0]   paddr,
  input  logic        [tkas_pkg::DATA_W-1:0]   pwdata,
  output logic        [tkas_pkg::DATA_W-1:0]   prdata,
  output logic                                 pready
);
  import tkas_pkg::*;

  cmd_t              cmd;
  status_t           status;
  slot_t             rank;
  logic              accept;
  logic              keep_we;
  logic [KEEP_W-1:0] keep_count;

  assign accept = start && !busy;

  // Register decode
  assign pready  = 1'b1;
  assign keep_we = psel && penable && pwrite && pready && (paddr[2] == REG_KEEP_COUNT);

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_KEEP_COUNT: prdata = DATA_W'(keep_count);
      default:        prdata = '0;
    endcase
  end

  tkas_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .final_i  (final_item_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  tkas_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .coeff_value_i   (coeff_value_i),
    .class_alpha_i   (class_alpha_i),
    .class_beta_i    (class_beta_i),
    .index_alpha_i   (index_alpha_i),
    .index_beta_i    (index_beta_i),
    .keep_we_i       (keep_we),
    .keep_wdata_i    (pwdata[KEEP_W-1:0]),
    .keep_count_o    (keep_count),
    .cmd_i           (cmd),
    .status_o        (status),
    .rank_valid_o    (rank_valid_o),
    .end_of_report_o (end_of_report_o),
    .rank_o          (rank)
  );

  // Unpack the result beat
  assign rank_magnitude_o   = rank.mag;
  assign rank_value_o       = rank.value;
  assign rank_class_alpha_o = rank.class_alpha;
  assign rank_class_beta_o  = rank.class_beta;
  assign rank_index_alpha_o = rank.index_alpha;
  assign rank_index_beta_o  = rank.index_beta;

endmodule

FILE: rtl/core/tkas_ctrl.sv
// ---------------------------------------------------------------------------
// tkas_ctrl
// Report sequencer: walks the ranks after the final item, then clears.
// ---------------------------------------------------------------------------
`include "top_k_abs_select_macros.svh"

module tkas_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              final_i,
  input  tkas_pkg::status_t status_i,
  output tkas_pkg::cmd_t    cmd_o,
  output logic              busy_o
);
  import tkas_pkg::*;

  state_e            state_q, state_d;
  logic [RANK_W-1:0] rank_q, rank_d;
  logic [RANK_W-1:0] last_q, last_d;
  logic              at_last;

  assign at_last = (rank_q == last_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept_i && final_i) state_d = ST_REPORT;
      end
      ST_REPORT: begin
        if (at_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
      end
      ST_REPORT: begin
        busy_o      = 1'b1;
        cmd_o.emit  = 1'b1;
        cmd_o.last  = at_last;
        cmd_o.clear = at_last;
        cmd_o.rank  = rank_q;
      end
      default: busy_o = 1'b0;
    endcase
  end

  // Rank counter and report length
  always_comb begin
    rank_d = rank_q;
    last_d = last_q;
    if (state_q == ST_IDLE) begin
      if (accept_i && final_i) begin
        rank_d = '0;
        last_d = status_i.last_rank;
      end
    end else if (!at_last) begin
      rank_d = rank_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rank_q  <= '0;
      last_q  <= '0;
    end else begin
      state_q <= state_d;
      rank_q  <= rank_d;
      last_q  <= last_d;
    end
  end

  `TKAS_ASSERT_NXT(a_final_starts_report, !busy_o && accept_i && final_i, state_q == ST_REPORT, "final item did not start a report")
  `TKAS_ASSERT_NXT(a_last_ends_report, cmd_o.emit && cmd_o.last, state_q == ST_IDLE, "report ran past its last rank")
  `TKAS_ASSERT_IMP(a_rank_in_range, state_q == ST_REPORT, rank_q <= last_q, "rank beyond report length")

endmodule

FILE: rtl/core/tkas_datapath.sv
// ---------------------------------------------------------------------------
// tkas_datapath
// Sorted slot list with parallel compare and shift-insert, result register
// and the keep_count register.
// ---------------------------------------------------------------------------
`include "top_k_abs_select_macros.svh"

module tkas_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 accept_i,
  input  logic signed [tkas_pkg::VAL_W-1:0]    coeff_value_i,
  input  logic        [tkas_pkg::CLS_W-1:0]    class_alpha_i,
  input  logic        [tkas_pkg::CLS_W-1:0]    class_beta_i,
  input  logic        [tkas_pkg::IDX_W-1:0]    index_alpha_i,
  input  logic        [tkas_pkg::IDX_W-1:0]    index_beta_i,
  input  logic                                 keep_we_i,
  input  logic        [tkas_pkg::KEEP_W-1:0]   keep_wdata_i,
  output logic        [tkas_pkg::KEEP_W-1:0]   keep_count_o,
  input  tkas_pkg::cmd_t                       cmd_i,
  output tkas_pkg::status_t                    status_o,
  output logic                                 rank_valid_o,
  output logic                                 end_of_report_o,
  output tkas_pkg::slot_t                      rank_o
);
  import tkas_pkg::*;

  slot_t               slot_q [MAX_KEEP];
  slot_t               slot_d [MAX_KEEP];
  logic [MAX_KEEP-1:0] valid_q, valid_d;
  logic [MAX_KEEP-1:0] gt;
  logic [CNT_W-1:0]    cnt_q, cnt_d, cnt_inc;
  logic [KEEP_W-1:0]   keep_q;
  logic [CMP_W-1:0]    k_ext, k_eff, seen, n_rep;
  slot_t               item;
  slot_t               rd_slot;
  slot_t               out_q;
  logic                strobe_q, eor_q;

  // Build the incoming element
  always_comb begin
    item             = '0;
    item.mag         = sat_mag(coeff_value_i);
    item.value       = coeff_value_i;
    item.class_alpha = class_alpha_i;
    item.class_beta  = class_beta_i;
    item.index_alpha = index_alpha_i;
    item.index_beta  = index_beta_i;
  end

  // Compare against every slot; an empty slot counts as zero
  always_comb begin
    for (int i = 0; i < MAX_KEEP; i++) begin
      gt[i] = valid_q[i] ? (item.mag > slot_q[i].mag) : (item.mag != '0);
    end
  end

  // Shift-insert: the first larger-than slot takes the item, later ones shift down
  always_comb begin
    valid_d = valid_q;
    for (int i = 0; i < MAX_KEEP; i++) begin
      slot_d[i] = slot_q[i];
    end
    if (cmd_i.clear) begin
      valid_d = '0;
    end else if (accept_i && gt[MAX_KEEP-1]) begin
      for (int i = 0; i < MAX_KEEP; i++) begin
        if (gt[i]) begin
          if (i == 0) begin
            slot_d[i]  = item;
            valid_d[i] = 1'b1;
          end else if (!gt[(i > 0) ? i - 1 : 0]) begin
            slot_d[i]  = item;
            valid_d[i] = 1'b1;
          end else begin
            slot_d[i]  = slot_q[(i > 0) ? i - 1 : 0];
            valid_d[i] = valid_q[(i > 0) ? i - 1 : 0];
          end
        end
      end
    end
  end

  // Count items up to the list depth
  assign cnt_inc = (cnt_q == CNT_W'(MAX_KEEP)) ? cnt_q : cnt_q + 1'b1;

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.clear) begin
      cnt_d = '0;
    end else if (accept_i) begin
      cnt_d = cnt_inc;
    end
  end

  // Report length: min(K clamped to 1..MAX_KEEP, items seen incl. this one)
  always_comb begin
    k_ext = CMP_W'(keep_q);
    if (k_ext == '0) begin
      k_eff = CMP_W'(1);
    end else if (k_ext > CMP_W'(MAX_KEEP)) begin
      k_eff = CMP_W'(MAX_KEEP);
    end else begin
      k_eff = k_ext;
    end
    seen  = CMP_W'(cnt_inc);
    n_rep = (seen < k_eff) ? seen : k_eff;
    status_o.last_rank = RANK_W'(n_rep - 1'b1);
  end

  // Empty ranks read as all zero
  assign rd_slot = valid_q[cmd_i.rank] ? slot_q[cmd_i.rank] : '0;

  // Slot payload
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_KEEP; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= rd_slot;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      cnt_q    <= '0;
      keep_q   <= KEEP_RESET;
      strobe_q <= 1'b0;
      eor_q    <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      cnt_q    <= cnt_d;
      strobe_q <= cmd_i.emit;
      eor_q    <= cmd_i.emit && cmd_i.last;
      if (keep_we_i) begin
        keep_q <= keep_wdata_i;
      end
    end
  end

  assign keep_count_o    = keep_q;
  assign rank_valid_o    = strobe_q;
  assign end_of_report_o = eor_q;
  assign rank_o          = out_q;

  `TKAS_ASSERT_IMP(a_valid_prefix, 1'b1, ((valid_q + 1'b1) & valid_q) == '0, "slot valid bits not a prefix")
  `TKAS_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(MAX_KEEP), "item count beyond list depth")
  `TKAS_ASSERT_NXT(a_clear_empties, cmd_i.clear, valid_q == '0 && cnt_q == '0, "list not emptied after report")

endmodule

FILE: bench/tb_top_k_abs_select.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top_k_abs_select
// Streams coefficient vectors into the top-k magnitude selector and checks
// every ranked beat against a local sorted-slot predictor. Covers keep_count
// settings from zero to the 5-bit maximum, ties, saturation of the most
// negative value and zero-filled report tails.
// ---------------------------------------------------------------------------
module tb_top_k_abs_select;
  import tkas_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 7;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_HOLD   = 4;
  localparam int RANDOM_ITEMS = 100;

  localparam logic [ADDR_W-1:0] KEEP_ADDR  = ADDR_W'(0);
  localparam logic [ADDR_W-1:0] SPARE_ADDR = ADDR_W'(4);

  typedef enum logic [1:0] {
    OP_ITEM,
    OP_WRITE,
    OP_READ,
    OP_DRAIN
  } op_kind_e;

  typedef enum logic [2:0] {
    DRV_FETCH,
    DRV_GAP,
    DRV_ITEM,
    DRV_SETUP,
    DRV_ACCESS,
    DRV_DRAIN,
    DRV_DONE
  } drv_state_e;

  typedef struct {
    op_kind_e          kind;
    int unsigned       gap;
    logic [VAL_W-1:0]  value;
    logic [CLS_W-1:0]  class_alpha;
    logic [CLS_W-1:0]  class_beta;
    logic [IDX_W-1:0]  index_alpha;
    logic [IDX_W-1:0]  index_beta;
    logic              last;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } bench_op_t;

  typedef struct packed {
    slot_t slot;
    logic  eor;
  } rank_beat_t;

  // DUT connections
  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic signed [VAL_W-1:0]  coeff_value_i = '0;
  logic        [CLS_W-1:0]  class_alpha_i = '0;
  logic        [CLS_W-1:0]  class_beta_i = '0;
  logic        [IDX_W-1:0]  index_alpha_i = '0;
  logic        [IDX_W-1:0]  index_beta_i = '0;
  logic                     final_item_i = 1'b0;
  logic                     rank_valid_o;
  logic        [MAG_W-1:0]  rank_magnitude_o;
  logic signed [VAL_W-1:0]  rank_value_o;
  logic        [CLS_W-1:0]  rank_class_alpha_o;
  logic        [CLS_W-1:0]  rank_class_beta_o;
  logic        [IDX_W-1:0]  rank_index_alpha_o;
  logic        [IDX_W-1:0]  rank_index_beta_o;
  logic                     end_of_report_o;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic        [ADDR_W-1:0] paddr = '0;
  logic        [DATA_W-1:0] pwdata = '0;
  logic        [DATA_W-1:0] prdata;
  logic                     pready;

  // Stimulus and driver state
  bench_op_t   pending_ops[$];
  bench_op_t   cur_op;
  drv_state_e  drv_state = DRV_FETCH;
  int unsigned gap_cnt = 0;
  int unsigned hold_cnt = 0;

  // Predictor state
  slot_t             kept_slots[MAX_KEEP];
  logic [31:0]       seen_count;
  logic [KEEP_W-1:0] keep_reg;
  rank_beat_t        rank_expect[$];
  int unsigned       mismatches = 0;

  top_k_abs_select u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .coeff_value_i      (coeff_value_i),
    .class_alpha_i      (class_alpha_i),
    .class_beta_i       (class_beta_i),
    .index_alpha_i      (index_alpha_i),
    .index_beta_i       (index_beta_i),
    .final_item_i       (final_item_i),
    .rank_valid_o       (rank_valid_o),
    .rank_magnitude_o   (rank_magnitude_o),
    .rank_value_o       (rank_value_o),
    .rank_class_alpha_o (rank_class_alpha_o),
    .rank_class_beta_o  (rank_class_beta_o),
    .rank_index_alpha_o (rank_index_alpha_o),
    .rank_index_beta_o  (rank_index_beta_o),
    .end_of_report_o    (end_of_report_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // Generate the clock
  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Saturated absolute value; the most negative input clips to full scale
  function automatic logic [MAG_W-1:0] coeff_magnitude(input logic [VAL_W-1:0] v);
    logic [VAL_W-1:0] flipped;
    flipped = -v;
    if (!v[VAL_W-1]) begin
      return v[MAG_W-1:0];
    end
    if (v == {1'b1, {(VAL_W-1){1'b0}}}) begin
      return {MAG_W{1'b1}};
    end
    return flipped[MAG_W-1:0];
  endfunction

  // Empty the sorted list for the next vector
  task automatic clear_kept();
    foreach (kept_slots[i]) begin
      kept_slots[i] = '0;
    end
    seen_count = '0;
  endtask

  // Insert one coefficient into the sorted list; on the final item queue the report
  task automatic rank_coeff(input logic [VAL_W-1:0] v, input logic [CLS_W-1:0] ca,
                            input logic [CLS_W-1:0] cb, input logic [IDX_W-1:0] ia,
                            input logic [IDX_W-1:0] ib, input logic last);
    logic [MAG_W-1:0] m;
    int               pos;
    int unsigned      k;
    int unsigned      n;
    rank_beat_t       beat;
    m = coeff_magnitude(v);
    if (seen_count != '1) begin
      seen_count = seen_count + 1;
    end
    if (m > kept_slots[MAX_KEEP-1].mag) begin
      pos = 0;
      while (pos < MAX_KEEP - 1 && !(m > kept_slots[pos].mag)) begin
        pos++;
      end
      for (int i = MAX_KEEP - 1; i > pos; i--) begin
        kept_slots[i] = kept_slots[i-1];
      end
      kept_slots[pos].mag         = m;
      kept_slots[pos].value       = v;
      kept_slots[pos].class_alpha = ca;
      kept_slots[pos].class_beta  = cb;
      kept_slots[pos].index_alpha = ia;
      kept_slots[pos].index_beta  = ib;
    end
    if (last) begin
      k = (keep_reg == 0) ? 1 : ((keep_reg > MAX_KEEP) ? MAX_KEEP : keep_reg);
      n = (seen_count < k) ? seen_count : k;
      for (int r = 0; r < n; r++) begin
        beat.slot = kept_slots[r];
        beat.eor  = (r == n - 1);
        rank_expect.push_back(beat);
      end
      clear_kept();
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // Compare one result beat with the oldest expectation
  task automatic check_rank_beat();
    rank_beat_t want;
    if (rank_expect.size() == 0) begin
      report_mismatch($sformatf("unexpected beat, value %h magnitude %h",
                                rank_value_o, rank_magnitude_o));
      return;
    end
    want = rank_expect.pop_front();
    if (rank_magnitude_o !== want.slot.mag)
      report_mismatch($sformatf("rank_magnitude got %h want %h",
                                rank_magnitude_o, want.slot.mag));
    if (rank_value_o !== want.slot.value)
      report_mismatch($sformatf("rank_value got %h want %h", rank_value_o, want.slot.value));
    if (rank_class_alpha_o !== want.slot.class_alpha)
      report_mismatch($sformatf("rank_class_alpha got %h want %h",
                                rank_class_alpha_o, want.slot.class_alpha));
    if (rank_class_beta_o !== want.slot.class_beta)
      report_mismatch($sformatf("rank_class_beta got %h want %h",
                                rank_class_beta_o, want.slot.class_beta));
    if (rank_index_alpha_o !== want.slot.index_alpha)
      report_mismatch($sformatf("rank_index_alpha got %h want %h",
                                rank_index_alpha_o, want.slot.index_alpha));
    if (rank_index_beta_o !== want.slot.index_beta)
      report_mismatch($sformatf("rank_index_beta got %h want %h",
                                rank_index_beta_o, want.slot.index_beta));
    if (end_of_report_o !== want.eor)
      report_mismatch($sformatf("end_of_report got %b want %b", end_of_report_o, want.eor));
  endtask

  // Put one operation on the ports
  task automatic launch_op(input bench_op_t op);
    case (op.kind)
      OP_ITEM: begin
        start         <= 1'b1;
        coeff_value_i <= op.value;
        class_alpha_i <= op.class_alpha;
        class_beta_i  <= op.class_beta;
        index_alpha_i <= op.index_alpha;
        index_beta_i  <= op.index_beta;
        final_item_i  <= op.last;
        drv_state     <= DRV_ITEM;
      end
      OP_WRITE, OP_READ: begin
        psel      <= 1'b1;
        penable   <= 1'b0;
        pwrite    <= (op.kind == OP_WRITE);
        paddr     <= op.addr;
        pwdata    <= op.wdata;
        drv_state <= DRV_SETUP;
      end
      default: begin
        hold_cnt  <= 0;
        drv_state <= DRV_DRAIN;
      end
    endcase
  endtask

  // Driver: play the pending operations with their gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start     <= 1'b0;
      psel      <= 1'b0;
      penable   <= 1'b0;
      pwrite    <= 1'b0;
      drv_state <= DRV_FETCH;
    end else begin
      case (drv_state)
        DRV_FETCH: begin
          if (pending_ops.size() == 0) begin
            drv_state <= DRV_DONE;
          end else begin
            cur_op = pending_ops.pop_front();
            if (cur_op.gap == 0) begin
              launch_op(cur_op);
            end else begin
              gap_cnt   <= cur_op.gap;
              drv_state <= DRV_GAP;
            end
          end
        end
        DRV_GAP: begin
          if (gap_cnt <= 1) begin
            launch_op(cur_op);
          end else begin
            gap_cnt <= gap_cnt - 1;
          end
        end
        // Hold the beat until taken; chain back-to-back items without dropping start
        DRV_ITEM: begin
          if (!busy) begin
            if (pending_ops.size() > 0 && pending_ops[0].kind == OP_ITEM &&
                pending_ops[0].gap == 0) begin
              cur_op = pending_ops.pop_front();
              launch_op(cur_op);
            end else begin
              start     <= 1'b0;
              drv_state <= DRV_FETCH;
            end
          end
        end
        DRV_SETUP: begin
          penable   <= 1'b1;
          drv_state <= DRV_ACCESS;
        end
        DRV_ACCESS: begin
          if (pready) begin
            psel      <= 1'b0;
            penable   <= 1'b0;
            pwrite    <= 1'b0;
            drv_state <= DRV_FETCH;
          end
        end
        // Wait out every pending report, then a quiet hold before the next operation
        DRV_DRAIN: begin
          if (rank_expect.size() == 0 && !busy) begin
            if (hold_cnt >= DRAIN_HOLD - 1) begin
              drv_state <= DRV_FETCH;
            end else begin
              hold_cnt <= hold_cnt + 1;
            end
          end else begin
            hold_cnt <= 0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Monitor: predict on accepted items and writes, check reads and result beats
  always @(posedge clk_i or negedge rst_ni) begin
    if (rst_ni) begin
      if (rank_valid_o) begin
        check_rank_beat();
      end
      if (start && !busy) begin
        rank_coeff(coeff_value_i, class_alpha_i, class_beta_i, index_alpha_i,
                   index_beta_i, final_item_i);
      end
      if (psel && penable && pready) begin
        if (pwrite && paddr == KEEP_ADDR) begin
          keep_reg = pwdata[KEEP_W-1:0];
        end else if (!pwrite && paddr == KEEP_ADDR && prdata[KEEP_W-1:0] !== keep_reg) begin
          report_mismatch($sformatf("keep_count read %h want %h",
                                    prdata[KEEP_W-1:0], keep_reg));
        end
      end
    end
  end

  // Stimulus builders
  function automatic int unsigned pick_gap(input bit burst);
    int unsigned r;
    if (burst) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [VAL_W-1:0] pick_coeff();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'h8000_0000;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0001;
      4, 5:    return VAL_W'($signed($urandom_range(0, 8)) - 4);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [KEEP_W-1:0] pick_keep();
    case ($urandom_range(0, 5))
      0:       return KEEP_W'(0);
      1:       return KEEP_W'(1);
      2:       return KEEP_W'(16);
      3:       return KEEP_W'(31);
      default: return KEEP_W'($urandom_range(0, 31));
    endcase
  endfunction

  task automatic add_item(input logic [VAL_W-1:0] v, input logic [CLS_W-1:0] ca,
                          input logic [CLS_W-1:0] cb, input logic [IDX_W-1:0] ia,
                          input logic [IDX_W-1:0] ib, input logic last,
                          input int unsigned gap);
    bench_op_t op;
    op = '{kind: OP_ITEM, gap: gap, value: v, class_alpha: ca, class_beta: cb,
           index_alpha: ia, index_beta: ib, last: last, addr: '0, wdata: '0};
    pending_ops.push_back(op);
  endtask

  task automatic add_bus(input op_kind_e kind, input logic [ADDR_W-1:0] addr,
                         input logic [DATA_W-1:0] data);
    bench_op_t op;
    op = '{kind: kind, gap: 0, value: '0, class_alpha: '0, class_beta: '0,
           index_alpha: '0, index_beta: '0, last: 1'b0, addr: addr, wdata: data};
    pending_ops.push_back(op);
  endtask

  // Idle the block, write keep_count with random upper bits, read it back
  task automatic add_keep(input logic [KEEP_W-1:0] k);
    add_bus(OP_DRAIN, '0, '0);
    add_bus(OP_WRITE, KEEP_ADDR, {$urandom} & ~DATA_W'({KEEP_W{1'b1}}) | DATA_W'(k));
    add_bus(OP_READ, KEEP_ADDR, '0);
  endtask

  initial begin
    int unsigned sent;
    int unsigned len;
    bit          burst;

    keep_reg = KEEP_RESET;
    clear_kept();

    // Directed: extremes, ties, saturation, zero items, K clamping
    add_bus(OP_READ, KEEP_ADDR, '0);
    add_item(32'h7FFF_FFFF, 8'hFF, 8'h00, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 0);
    add_item(32'h8000_0000, 8'h00, 8'hFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 0);
    add_item(32'h0000_0000, 8'h5A, 8'hA5, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 0);
    add_item(32'hFFFF_FFFF, 8'h01, 8'h02, 32'h0000_0003, 32'h0000_0004, 1'b0, 2);
    add_item(32'h0000_0001, 8'h11, 8'h22, 32'h0000_0033, 32'h0000_0044, 1'b0, 0);
    add_item(32'h4000_0000, 8'h80, 8'h7F, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 0);
    add_item(32'hC000_0000, 8'h7F, 8'h80, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 0);
    add_item(32'h0000_0000, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 0);
    add_keep(KEEP_W'(0));
    add_item(32'h0000_0005, 8'h03, 8'h04, 32'h0000_0005, 32'h0000_0006, 1'b0, 0);
    add_item(32'hFFFF_FFF7, 8'h07, 8'h08, 32'h0000_0009, 32'h0000_000A, 1'b0, 0);
    add_item(32'h0000_0009, 8'h0B, 8'h0C, 32'h0000_000D, 32'h0000_000E, 1'b1, 0);
    // A write beyond the register map must leave keep_count alone
    add_bus(OP_DRAIN, '0, '0);
    add_bus(OP_WRITE, SPARE_ADDR, 32'hFFFF_FFFF);
    add_bus(OP_READ, KEEP_ADDR, '0);
    add_keep(KEEP_W'(31));
    add_item(32'h0000_0100, 8'h21, 8'h22, 32'h0000_0023, 32'h0000_0024, 1'b0, 0);
    add_item(32'hFFFF_FE00, 8'h25, 8'h26, 32'h0000_0027, 32'h0000_0028, 1'b0, 0);
    // Change K mid-vector; the value at the final item decides the report length
    add_keep(KEEP_W'(2));
    add_item(32'h0000_0300, 8'h29, 8'h2A, 32'h0000_002B, 32'h0000_002C, 1'b0, 0);
    add_item(32'h0000_0001, 8'h2D, 8'h2E, 32'h0000_002F, 32'h0000_0030, 1'b0, 0);
    add_item(32'h0000_0200, 8'h31, 8'h32, 32'h0000_0033, 32'h0000_0034, 1'b1, 0);

    // Random vectors, with occasional K changes and full drains
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0) begin
        add_keep(pick_keep());
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      for (int i = 0; i < len; i++) begin
        if (i > 0 && $urandom_range(0, 40) == 0) begin
          add_bus(OP_DRAIN, '0, '0);
        end
        add_item(pick_coeff(), CLS_W'($urandom), CLS_W'($urandom), $urandom, $urandom,
                 (i == len - 1), pick_gap(burst));
        sent++;
      end
    end
    add_keep(KEEP_W'(16));
    add_item($urandom, CLS_W'($urandom), CLS_W'($urandom), $urandom, $urandom, 1'b1, 0);

    // Release reset, then wait for the stimulus and the reports to finish
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (drv_state != DRV_DONE) @(posedge clk_i);
    while (rank_expect.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_top_k_abs_select OK");
    end else begin
      $display("tb_top_k_abs_select NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("tb_top_k_abs_select NOT OK");
    $finish;
  end

endmodule
